// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FSP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FSP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FSP_ASSERT(lbl, clk, rst_n, prop, msg)
`define FSP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/fsp_pkg.sv =====
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types and defaults of the format specifier parser
// ----------------------------------------------------------------------------
package fsp_pkg;

    localparam int FSP_LENGTH_BITS = 16;
    localparam int FSP_QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_PCT = 2'd1,
        ST_BAD = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SZ_NONE  = 2'd0,
        SZ_H     = 2'd1,
        SZ_L     = 2'd2,
        SZ_BIG_L = 2'd3
    } t_size;

    typedef enum logic [3:0] {
        K_OTHER,
        K_MINUS,
        K_PLUS,
        K_SPACE,
        K_ALT,
        K_ZERO,
        K_PCT,
        K_STAR,
        K_DOT
    } t_kind;

    // classified character as it travels from front to back
    typedef struct packed {
        logic        start;
        t_kind       kind;
        logic        is_digit;
        logic [3:0]  digit;
        t_size       size;
        logic        conv_ok;
        logic        conv_f;
        logic        conv_d;
        logic        star_pos;
        logic [30:0] star_val;
        logic [7:0]  code;
    } t_chr_cls;

    typedef struct packed {
        logic zero;
        logic alt;
        logic space;
        logic plus;
        logic minus;
    } t_flags;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/fsp_front.sv =====
// ----------------------------------------------------------------------------
// fsp_front
// Character classifier: decodes flags, digits, size letters and conversions
// ----------------------------------------------------------------------------
module fsp_front import fsp_pkg::*; (
    input  logic        i_start,
    input  logic [7:0]  i_char,
    input  logic [31:0] i_star,
    output t_chr_cls    o_cls
);

    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_LC_H  = 8'h68;
    localparam logic [7:0] CH_LC_L  = 8'h6c;
    localparam logic [7:0] CH_UC_L  = 8'h4c;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_D  = 8'h64;

    always_comb begin
        o_cls          = '0;
        o_cls.start    = i_start;
        o_cls.code     = i_char;
        o_cls.star_pos = (i_star != 32'd0) && !i_star[31];
        o_cls.star_val = i_star[30:0];
        o_cls.is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        o_cls.digit    = i_char[3:0];
        o_cls.conv_f   = (i_char == CH_LC_F);
        o_cls.conv_d   = (i_char == CH_LC_D);

        case (i_char)
            CH_MINUS: o_cls.kind = K_MINUS;
            CH_PLUS:  o_cls.kind = K_PLUS;
            CH_SPACE: o_cls.kind = K_SPACE;
            CH_HASH:  o_cls.kind = K_ALT;
            CH_ZERO:  o_cls.kind = K_ZERO;
            CH_PCT:   o_cls.kind = K_PCT;
            CH_STAR:  o_cls.kind = K_STAR;
            CH_DOT:   o_cls.kind = K_DOT;
            default:  o_cls.kind = K_OTHER;
        endcase

        case (i_char)
            CH_LC_H: o_cls.size = SZ_H;
            CH_LC_L: o_cls.size = SZ_L;
            CH_UC_L: o_cls.size = SZ_BIG_L;
            default: o_cls.size = SZ_NONE;
        endcase

        // c d i e E f g G o s u x X p n
        case (i_char)
            8'h63, 8'h64, 8'h69, 8'h65, 8'h45, 8'h66, 8'h67, 8'h47,
            8'h6f, 8'h73, 8'h75, 8'h78, 8'h58, 8'h70, 8'h6e: o_cls.conv_ok = 1'b1;
            default:                                        o_cls.conv_ok = 1'b0;
        endcase
    end

endmodule

// ===== rtl/fsp_queue.sv =====
// ----------------------------------------------------------------------------
// fsp_queue
// Short FIFO of classified characters between front and back
// ----------------------------------------------------------------------------
module fsp_queue import fsp_pkg::*; #(
    parameter int DEPTH = FSP_QUEUE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_chr_cls i_data,
    input  logic     i_pop,
    output t_chr_cls o_data,
    output t_q_stat  o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_chr_cls          r_mem [DEPTH];
    logic     [AW-1:0] r_wr_ptr;
    logic     [AW-1:0] r_rd_ptr;
    logic     [CW-1:0] r_count;
    logic     [AW-1:0] n_wr_ptr;
    logic     [AW-1:0] n_rd_ptr;
    logic     [CW-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// ===== rtl/fsp_back.sv =====
// ----------------------------------------------------------------------------
// fsp_back
// Parse state machine and result register of the format specifier parser
// ----------------------------------------------------------------------------
module fsp_back import fsp_pkg::*; #(
    parameter int LENGTH_BITS = FSP_LENGTH_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_chr_cls               i_item,
    input  logic                   i_item_valid,
    output logic                   o_item_pop,
    output logic                   o_res_valid,
    input  logic                   i_res_ready,
    output t_status                o_status,
    output logic [LENGTH_BITS-1:0] o_length,
    output t_flags                 o_flags,
    output logic [30:0]            o_width,
    output logic [30:0]            o_prec,
    output logic                   o_prec_given,
    output t_size                  o_size,
    output logic [7:0]             o_conv
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FLAGS,
        PH_WDIG,
        PH_POPT,
        PH_PREC,
        PH_SIZE,
        PH_CONV
    } t_phase;

    function automatic logic [30:0] acc_digit(input logic [30:0] acc, input logic [3:0] d);
        logic [34:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, d};
        return (|v[34:31]) ? 31'h7fff_ffff : v[30:0];
    endfunction

    t_phase                 r_phase, n_phase, e_phase;
    t_flags                 r_pflags, n_pflags, e_pflags;
    logic [30:0]            r_wacc, n_wacc, e_wacc;
    logic [30:0]            r_pacc, n_pacc, e_pacc;
    logic                   r_pseen, n_pseen, e_pseen;
    t_size                  r_psize, n_psize, e_psize;
    logic [LENGTH_BITS-1:0] r_cnt, n_cnt, e_cnt;

    logic                   r_out_valid;
    t_status                r_status, n_status;
    logic [LENGTH_BITS-1:0] r_length, n_length;
    t_flags                 r_flags;
    logic [30:0]            r_width;
    logic [30:0]            r_prec;
    logic                   r_prec_given;
    t_size                  r_size;
    logic [7:0]             r_conv;

    logic pop, take, emit, flag_bad;
    logic chk_popt, chk_prec, chk_size, chk_conv;

    assign pop = i_item_valid && (!r_out_valid || i_res_ready);

    always_comb begin
        e_phase  = i_item.start ? PH_FLAGS : r_phase;
        e_pflags = i_item.start ? '0 : r_pflags;
        e_wacc   = i_item.start ? '0 : r_wacc;
        e_pacc   = i_item.start ? '0 : r_pacc;
        e_pseen  = i_item.start ? 1'b0 : r_pseen;
        e_psize  = i_item.start ? SZ_NONE : r_psize;
        e_cnt    = i_item.start ? '0 : r_cnt;

        n_phase  = e_phase;
        n_pflags = e_pflags;
        n_wacc   = e_wacc;
        n_pacc   = e_pacc;
        n_pseen  = e_pseen;
        n_psize  = e_psize;
        take     = 1'b0;
        emit     = 1'b0;
        n_status = ST_BAD;
        chk_popt = 1'b0;
        chk_prec = 1'b0;
        chk_size = 1'b0;
        chk_conv = 1'b0;

        case (i_item.kind)
            K_MINUS: flag_bad = e_pflags.minus;
            K_PLUS:  flag_bad = e_pflags.plus | e_pflags.space;
            K_SPACE: flag_bad = |e_pflags;
            K_ALT:   flag_bad = e_pflags.alt;
            K_ZERO:  flag_bad = e_pflags.zero;
            K_PCT:   flag_bad = e_pflags.plus | e_pflags.space;
            default: flag_bad = 1'b0;
        endcase

        case (e_phase)
            PH_FLAGS: begin
                case (i_item.kind)
                    K_MINUS, K_PLUS, K_SPACE, K_ALT, K_ZERO, K_PCT: begin
                        take = 1'b1;
                        if (flag_bad) begin
                            emit = 1'b1;
                        end else begin
                            case (i_item.kind)
                                K_MINUS: n_pflags.minus = 1'b1;
                                K_PLUS:  n_pflags.plus  = 1'b1;
                                K_SPACE: n_pflags.space = 1'b1;
                                K_ALT:   n_pflags.alt   = 1'b1;
                                K_ZERO:  n_pflags.zero  = 1'b1;
                                default: begin
                                    emit     = 1'b1;
                                    n_status = ST_PCT;
                                end
                            endcase
                        end
                    end
                    K_STAR: begin
                        if (i_item.star_pos) begin
                            n_wacc = i_item.star_val;
                        end
                        take    = 1'b1;
                        n_phase = PH_POPT;
                    end
                    default: begin
                        if (i_item.is_digit) begin
                            n_wacc  = acc_digit(e_wacc, i_item.digit);
                            take    = 1'b1;
                            n_phase = PH_WDIG;
                        end else begin
                            chk_popt = 1'b1;
                        end
                    end
                endcase
            end
            PH_WDIG: begin
                if (i_item.is_digit) begin
                    n_wacc = acc_digit(e_wacc, i_item.digit);
                    take   = 1'b1;
                end else begin
                    chk_popt = 1'b1;
                end
            end
            PH_POPT: chk_popt = 1'b1;
            PH_PREC: chk_prec = 1'b1;
            PH_SIZE: chk_size = 1'b1;
            PH_CONV: chk_conv = 1'b1;
            default: ;
        endcase

        if (chk_popt) begin
            if (i_item.kind == K_DOT) begin
                take    = 1'b1;
                n_phase = PH_PREC;
            end else begin
                chk_size = 1'b1;
            end
        end

        if (chk_prec) begin
            if (i_item.kind == K_STAR && !e_pseen) begin
                if (i_item.star_pos) begin
                    n_pacc  = i_item.star_val;
                    n_pseen = 1'b1;
                end
                take    = 1'b1;
                n_phase = PH_SIZE;
            end else if (i_item.is_digit) begin
                n_pacc  = acc_digit(e_pacc, i_item.digit);
                n_pseen = 1'b1;
                take    = 1'b1;
            end else begin
                chk_size = 1'b1;
            end
        end

        if (chk_size) begin
            if (i_item.size != SZ_NONE) begin
                n_psize = i_item.size;
                take    = 1'b1;
                n_phase = PH_CONV;
            end else begin
                chk_conv = 1'b1;
            end
        end

        if (chk_conv) begin
            emit = 1'b1;
            if (i_item.conv_ok && !(i_item.conv_f && e_psize == SZ_H)
                    && !(i_item.conv_d && e_psize == SZ_BIG_L)) begin
                take     = 1'b1;
                n_status = ST_OK;
            end
        end

        n_cnt = (take && e_cnt != '1) ? e_cnt + 1'b1 : e_cnt;

        if (emit) begin
            n_phase = PH_IDLE;
        end

        case (n_status)
            ST_OK:   n_length = n_cnt;
            ST_PCT:  n_length = LENGTH_BITS'(1);
            default: n_length = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_phase  <= n_phase;
                r_pflags <= n_pflags;
                r_wacc   <= n_wacc;
                r_pacc   <= n_pacc;
                r_pseen  <= n_pseen;
                r_psize  <= n_psize;
                r_cnt    <= n_cnt;
            end
            if (pop && emit) begin
                r_out_valid  <= 1'b1;
                r_status     <= n_status;
                r_length     <= n_length;
                r_flags      <= (n_status == ST_OK) ? n_pflags : '0;
                r_width      <= (n_status == ST_OK) ? n_wacc : '0;
                r_prec       <= (n_status == ST_OK) ? n_pacc : '0;
                r_prec_given <= (n_status == ST_OK) && n_pseen;
                r_size       <= (n_status == ST_OK) ? n_psize : SZ_NONE;
                r_conv       <= (n_status == ST_OK) ? i_item.code : 8'd0;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_item_pop   = pop;
    assign o_res_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_length     = r_length;
    assign o_flags      = r_flags;
    assign o_width      = r_width;
    assign o_prec       = r_prec;
    assign o_prec_given = r_prec_given;
    assign o_size       = r_size;
    assign o_conv       = r_conv;

endmodule

// ===== rtl/format_specifier_parser_top.sv =====
// ----------------------------------------------------------------------------
// format_specifier_parser_top
// Streaming parser of printf conversion specifiers, while the queue has room one character per cycle
// ----------------------------------------------------------------------------
// usage:
//   slave side takes the characters after a percent sign, one per transaction;
//   tuser marks the first character of a specifier and restarts the parse,
//   tdata carries the character and the star argument for an asterisk
//   master side gives one transaction per finished specifier: status in tuser,
//   length, flags, width, precision, size code and conversion in tdata
//   one character per cycle while the queue is not full; a result shows on
//   the master side once the character that ends it has been written into
//   the classifier queue and then taken into the result register
//   the queue (QUEUE_DEPTH entries) lets the slave side keep taking
//   characters while a result waits; when the receiver stalls, tready on
//   the slave side drops once the queue fills
//   reset empties the queue, drops a pending result and returns to idle;
//   characters without a start mark are ignored while idle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module format_specifier_parser_top import fsp_pkg::*; #(
    parameter int LENGTH_BITS = FSP_LENGTH_BITS,
    parameter int QUEUE_DEPTH = FSP_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // char_code[7:0], star_value[39:8]
    input  logic [39:0] i_s_tdata,
    // start_req
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // length, flag_minus, flag_plus, flag_space, flag_alt, flag_zero, width,
    // precision, precision_given, size_code, conversion, zero fill
    output logic [((LENGTH_BITS + 78 + 7) / 8) * 8 - 1:0] o_m_tdata,
    // status
    output logic [1:0]  o_m_tuser
);

    localparam int OUT_W = ((LENGTH_BITS + 78 + 7) / 8) * 8;

    t_chr_cls               cls;
    t_chr_cls               q_head;
    t_q_stat                q_stat;
    logic                   push;
    logic                   pop;
    t_status                res_status;
    logic [LENGTH_BITS-1:0] res_length;
    t_flags                 res_flags;
    logic [30:0]            res_width;
    logic [30:0]            res_prec;
    logic                   res_prec_given;
    t_size                  res_size;
    logic [7:0]             res_conv;
    logic                   res_ok;
    logic                   res_pct;
    logic                   res_bad;
    logic                   res_len_one;
    logic                   res_empty;
    logic                   q_first;

    assign o_s_tready = !q_stat.full;
    assign push       = i_s_tvalid && o_s_tready;

    fsp_front u_front (
        .i_start (i_s_tuser),
        .i_char  (i_s_tdata[7:0]),
        .i_star  (i_s_tdata[39:8]),
        .o_cls   (cls)
    );

    fsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls),
        .i_pop   (pop),
        .o_data  (q_head),
        .o_stat  (q_stat)
    );

    fsp_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (q_head),
        .i_item_valid (!q_stat.empty),
        .o_item_pop   (pop),
        .o_res_valid  (o_m_tvalid),
        .i_res_ready  (i_m_tready),
        .o_status     (res_status),
        .o_length     (res_length),
        .o_flags      (res_flags),
        .o_width      (res_width),
        .o_prec       (res_prec),
        .o_prec_given (res_prec_given),
        .o_size       (res_size),
        .o_conv       (res_conv)
    );

    assign o_m_tuser = res_status;
    assign o_m_tdata = OUT_W'({res_conv, res_size, res_prec_given, res_prec, res_width,
                               res_flags.zero, res_flags.alt, res_flags.space,
                               res_flags.plus, res_flags.minus, res_length});

    assign res_ok      = o_m_tvalid && (o_m_tuser == ST_OK);
    assign res_pct     = o_m_tvalid && (o_m_tuser == ST_PCT);
    assign res_bad     = o_m_tvalid && (o_m_tuser == ST_BAD);
    assign res_len_one = (res_length == LENGTH_BITS'(1));
    assign res_empty   = (res_conv == 8'd0) || (res_length == '0);
    assign q_first     = push && q_stat.empty;

    `FSP_ASSERT(a_pct_len, i_clk, i_rst_n, res_pct |-> res_len_one, "percent result length")
    `FSP_ASSERT(a_bad_zero, i_clk, i_rst_n, res_bad |-> (o_m_tdata == '0), "invalid fields set")
    `FSP_ASSERT_NEVER(a_ok_conv, i_clk, i_rst_n, res_ok && res_empty, "valid result incomplete")
    `FSP_ASSERT(a_q_fill, i_clk, i_rst_n, q_first |=> !q_stat.empty, "queue lost a push")

endmodule

// ===== tb/format_specifier_parser_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// format_specifier_parser_top_tb
// Streams printf conversion specifiers into the parser one character per
// transaction, predicts each finished specifier in a cycle-free model of the
// parse, and checks every result field against it under random bursts, gaps
// and receiver stalls
// ----------------------------------------------------------------------------
module format_specifier_parser_top_tb;
    import fsp_pkg::*;

    localparam int LB       = FSP_LENGTH_BITS;
    localparam int FIELDS_W = LB + 78;
    localparam int OUT_W    = ((LB + 78 + 7) / 8) * 8;

    localparam logic [5:0] FB_MINUS = 6'b000001;
    localparam logic [5:0] FB_PLUS  = 6'b000010;
    localparam logic [5:0] FB_SPACE = 6'b000100;
    localparam logic [5:0] FB_ALT   = 6'b001000;
    localparam logic [5:0] FB_ZERO  = 6'b010000;
    localparam logic [5:0] FB_PCT   = 6'b100000;

    localparam logic [30:0] VAL_MAX = 31'h7FFF_FFFF;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FLAGS,
        PH_WDIG,
        PH_POPT,
        PH_PREC,
        PH_SIZE,
        PH_CONV
    } t_parse_phase;

    typedef struct packed {
        logic [7:0]    conversion;
        t_size         size_code;
        logic          precision_given;
        logic [30:0]   precision;
        logic [30:0]   width;
        logic          flag_zero, flag_alt, flag_space, flag_plus, flag_minus;
        logic [LB-1:0] length;
    } t_spec_fields;

    typedef struct packed {
        t_status      status;
        t_spec_fields f;
    } t_spec_result;

    typedef struct packed {
        logic        start;
        logic [7:0]  ch;
        logic [31:0] star;
    } t_fmt_char;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [39:0]      i_s_tdata = '0;
    logic             i_s_tuser = 1'b0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;
    logic [1:0]       o_m_tuser;

    format_specifier_parser_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_fmt_char    char_q[$];
    t_spec_result expected_specs[$];
    int           mismatches = 0;
    int           chars_taken = 0;
    logic         s_taken = 1'b0;

    // parse state of the predictor
    t_parse_phase  ph = PH_IDLE;
    logic [5:0]    flag_bits = '0;
    logic [30:0]   wacc = '0;
    logic [30:0]   pacc = '0;
    logic          pseen = 1'b0;
    t_size         sz = SZ_NONE;
    logic [LB-1:0] consumed = '0;

    function automatic logic [30:0] add_digit(input logic [30:0] acc, input logic [7:0] ch);
        logic [35:0] v;
        v = 36'(acc) * 36'd10 + 36'(ch - "0");
        return (v > 36'(VAL_MAX)) ? VAL_MAX : v[30:0];
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return ch >= "0" && ch <= "9";
    endfunction

    task automatic count_char();
        if (consumed != '1)
            consumed = consumed + 1'b1;
    endtask

    task automatic emit_spec(input t_status st, input logic [7:0] conv);
        t_spec_result r;
        r = '0;
        r.status = st;
        if (st == ST_OK) begin
            r.f.length          = consumed;
            r.f.flag_minus      = |(flag_bits & FB_MINUS);
            r.f.flag_plus       = |(flag_bits & FB_PLUS);
            r.f.flag_space      = |(flag_bits & FB_SPACE);
            r.f.flag_alt        = |(flag_bits & FB_ALT);
            r.f.flag_zero       = |(flag_bits & FB_ZERO);
            r.f.width           = wacc;
            r.f.precision       = pacc;
            r.f.precision_given = pseen;
            r.f.size_code       = sz;
            r.f.conversion      = conv;
        end else if (st == ST_PCT) begin
            r.f.length = LB'(1);
        end
        expected_specs.push_back(r);
        ph = PH_IDLE;
    endtask

    task automatic parse_char(input logic start, input logic [7:0] ch, input logic [31:0] sv);
        logic         star_pos;
        logic         is_flag;
        logic [5:0]   bad;
        logic [5:0]   set;
        t_parse_phase p;
        t_size        s;
        star_pos = sv != 0 && !sv[31];
        if (start) begin
            flag_bits = '0;
            wacc      = '0;
            pacc      = '0;
            pseen     = 1'b0;
            sz        = SZ_NONE;
            consumed  = '0;
            ph        = PH_FLAGS;
        end
        p = ph;
        if (p == PH_IDLE)
            return;
        if (p == PH_FLAGS) begin
            is_flag = 1'b1;
            bad = '0;
            set = '0;
            case (ch)
                "-": begin bad = FB_MINUS; set = FB_MINUS; end
                "+": begin bad = FB_PLUS | FB_SPACE; set = FB_PLUS; end
                " ": begin bad = '1; set = FB_SPACE; end
                "#": begin bad = FB_ALT; set = FB_ALT; end
                "0": begin bad = FB_ZERO; set = FB_ZERO; end
                "%": begin bad = FB_PLUS | FB_SPACE; set = FB_PCT; end
                default: is_flag = 1'b0;
            endcase
            if (is_flag) begin
                count_char();
                if ((flag_bits & bad) != 0) begin
                    emit_spec(ST_BAD, 8'd0);
                    return;
                end
                flag_bits = flag_bits | set;
                if (set == FB_PCT)
                    emit_spec(ST_PCT, 8'd0);
                return;
            end
            if (ch == "*") begin
                if (star_pos)
                    wacc = sv[30:0];
                count_char();
                ph = PH_POPT;
                return;
            end
            if (is_digit(ch)) begin
                wacc = add_digit(wacc, ch);
                count_char();
                ph = PH_WDIG;
                return;
            end
            p = PH_POPT;
        end
        if (p == PH_WDIG) begin
            if (is_digit(ch)) begin
                wacc = add_digit(wacc, ch);
                count_char();
                return;
            end
            p = PH_POPT;
        end
        if (p == PH_POPT) begin
            if (ch == ".") begin
                count_char();
                ph = PH_PREC;
                return;
            end
            p = PH_SIZE;
        end
        if (p == PH_PREC) begin
            if (ch == "*" && !pseen) begin
                if (star_pos) begin
                    pacc  = sv[30:0];
                    pseen = 1'b1;
                end
                count_char();
                ph = PH_SIZE;
                return;
            end
            if (is_digit(ch)) begin
                pacc  = add_digit(pacc, ch);
                pseen = 1'b1;
                count_char();
                return;
            end
            p = PH_SIZE;
        end
        if (p == PH_SIZE) begin
            s = (ch == "h") ? SZ_H : (ch == "l") ? SZ_L : (ch == "L") ? SZ_BIG_L : SZ_NONE;
            if (s != SZ_NONE) begin
                sz = s;
                count_char();
                ph = PH_CONV;
                return;
            end
        end
        if (ch inside {"c", "d", "i", "e", "E", "f", "g", "G",
                       "o", "s", "u", "x", "X", "p", "n"})
        begin
            if ((ch == "f" && sz == SZ_H) || (ch == "d" && sz == SZ_BIG_L)) begin
                emit_spec(ST_BAD, 8'd0);
                return;
            end
            count_char();
            emit_spec(ST_OK, ch);
            return;
        end
        emit_spec(ST_BAD, 8'd0);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // transaction monitor: prediction on accepted characters, check on results
    always @(posedge i_clk) begin
        t_spec_result want;
        t_spec_fields got;
        if (!i_rst_n) begin
            s_taken = 1'b0;
        end else begin
            s_taken = i_s_tvalid && o_s_tready;
            if (s_taken) begin
                chars_taken++;
                parse_char(i_s_tuser, i_s_tdata[7:0], i_s_tdata[39:8]);
            end
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata[FIELDS_W-1:0];
                if (expected_specs.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %0d 0x%0h",
                             $time, o_m_tuser, o_m_tdata);
                    mismatches++;
                end else begin
                    want = expected_specs.pop_front();
                    check_field("status", 32'(want.status), 32'(o_m_tuser));
                    check_field("length", 32'(want.f.length), 32'(got.length));
                    check_field("flag_minus", 32'(want.f.flag_minus), 32'(got.flag_minus));
                    check_field("flag_plus", 32'(want.f.flag_plus), 32'(got.flag_plus));
                    check_field("flag_space", 32'(want.f.flag_space), 32'(got.flag_space));
                    check_field("flag_alt", 32'(want.f.flag_alt), 32'(got.flag_alt));
                    check_field("flag_zero", 32'(want.f.flag_zero), 32'(got.flag_zero));
                    check_field("width", 32'(want.f.width), 32'(got.width));
                    check_field("precision", 32'(want.f.precision), 32'(got.precision));
                    check_field("precision_given", 32'(want.f.precision_given),
                                32'(got.precision_given));
                    check_field("size_code", 32'(want.f.size_code), 32'(got.size_code));
                    check_field("conversion", 32'(want.f.conversion), 32'(got.conversion));
                    check_field("zero fill", '0, 32'(o_m_tdata[OUT_W-1:FIELDS_W]));
                end
            end
        end
    end

    // character driver: bursts of random length with random gaps
    int burst_left = 1;
    int gap_left = 0;

    always @(negedge i_clk) begin
        t_fmt_char it;
        if (i_rst_n && !(i_s_tvalid && !s_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (char_q.size() > 0) begin
                it = char_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {it.star, it.ch};
                i_s_tuser  <= it.start;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 32);
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5, 6, 7:                 gap_left = 0;
                        8, 9, 10, 11, 12, 13, 14, 15, 16:       gap_left = $urandom_range(1, 3);
                        default:                                gap_left = $urandom_range(4, 24);
                    endcase
                end else begin
                    burst_left--;
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: stall pattern of its own plus one long hold-off
    int   hold_left = 0;
    logic hold_done = 1'b0;
    int   rx_mode = 0;
    int   rx_mode_left = 0;

    always @(negedge i_clk) begin
        logic rdy;
        rdy = 1'b0;
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
            end else if (!hold_done && chars_taken >= 200) begin
                hold_done = 1'b1;
                hold_left = 300;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode = $urandom_range(0, 2);
                    rx_mode_left = $urandom_range(8, 64);
                end else begin
                    rx_mode_left--;
                end
                case (rx_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = $urandom_range(0, 1);
                    default: rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
        i_m_tready <= rdy;
    end

    task automatic push_char(input logic start, input logic [7:0] ch, input logic [31:0] sv);
        t_fmt_char it;
        it.start = start;
        it.ch    = ch;
        it.star  = sv;
        char_q.push_back(it);
    endtask

    task automatic push_spec(input string s, input logic [31:0] sv);
        for (int i = 0; i < s.len(); i++)
            push_char(i == 0, s[i], sv);
    endtask

    function automatic logic [31:0] pick_star();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'h0000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            default: return $urandom_range(1, 1000);
        endcase
    endfunction

    task automatic push_digits(inout logic [7:0] spec[$]);
        int n;
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 3);
        spec.push_back(8'("0") + 8'($urandom_range(1, 9)));
        for (int i = 1; i < n; i++)
            spec.push_back(8'("0") + 8'($urandom_range(0, 9)));
    endtask

    // one random specifier, mostly well formed; returns how many characters the specifier uses
    task automatic gen_spec(output int n_chars);
        string       flag_chars;
        string       conv_chars;
        string       size_chars;
        logic [7:0]  spec[$];
        int          n;
        flag_chars = "-+ #0";
        conv_chars = "cdieEfgGosuxXpn";
        size_chars = "hlL";
        if ($urandom_range(0, 19) == 0) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                spec.push_back(8'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                spec.push_back(flag_chars[$urandom_range(0, 4)]);
            if ($urandom_range(0, 15) == 0)
                spec.push_back("%");
            case ($urandom_range(0, 2))
                1:       push_digits(spec);
                2:       spec.push_back("*");
                default: ;
            endcase
            if ($urandom_range(0, 1)) begin
                spec.push_back(".");
                case ($urandom_range(0, 2))
                    1:       push_digits(spec);
                    2:       spec.push_back("*");
                    default: ;
                endcase
            end
            if ($urandom_range(0, 1))
                spec.push_back(size_chars[$urandom_range(0, 2)]);
            if ($urandom_range(0, 19) < 17)
                spec.push_back(conv_chars[$urandom_range(0, 14)]);
            else
                spec.push_back(8'($urandom_range(0, 255)));
            // cut short now and then so the next start restarts mid parse
            if ($urandom_range(0, 9) == 0)
                spec = spec[0:$urandom_range(0, spec.size() - 1)];
        end
        foreach (spec[i])
            push_char(i == 0, spec[i], (spec[i] == "*") ? pick_star() : $urandom);
        n_chars = spec.size();
        // stray characters without a start mark
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                push_char(1'b0, 8'($urandom_range(0, 255)), $urandom);
        end
    endtask

    task automatic wait_drained();
        while (char_q.size() != 0 || i_s_tvalid || expected_specs.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        int spec_chars;
        int n;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed specifiers
        push_spec("%", $urandom);
        push_char(1'b0, "d", $urandom);
        push_spec("+%", $urandom);
        push_spec(" +", $urandom);
        push_spec("-#0+*.*Lf", 32'h7FFF_FFFF);
        push_spec("hf", $urandom);
        push_spec("Ld", $urandom);
        push_spec("*.*x", 32'h8000_0000);
        push_spec("12", $urandom);
        push_spec("c", $urandom);
        wait_drained();

        // random specifiers
        spec_chars = 0;
        while (spec_chars < 560) begin
            gen_spec(n);
            spec_chars += n;
        end
        wait_drained();

        if (mismatches == 0 && expected_specs.size() == 0)
            $display("format_specifier_parser_top verification clean");
        else
            $display("format_specifier_parser_top verification failed");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("format_specifier_parser_top verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fsp_pkg.sv
rtl/fsp_front.sv
rtl/fsp_queue.sv
rtl/fsp_back.sv
rtl/format_specifier_parser_top.sv
tb/format_specifier_parser_top_tb.sv
